// ===== rtl/gjs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gjs_pkg: shared types and constants of the Gauss-Jordan solver
// Holds the payload structs, the size constants and the divider interface.
// ----------------------------------------------------------------------------
package gjs_pkg;

  localparam int MAX_N      = 16;
  localparam int IDX_W      = $clog2(MAX_N);
  localparam int COL_W      = IDX_W + 1;
  localparam int SIZE_W     = 5;
  localparam int MAT_DEPTH  = MAX_N * MAX_N;
  localparam int MAT_AW     = $clog2(MAT_DEPTH);
  localparam int DATA_W     = 32;

  typedef struct packed {
    logic [IDX_W-1:0]         row_index;
    logic [COL_W-1:0]         col_index;
    logic signed [DATA_W-1:0] entry_value;
    logic                     last_entry;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         solution_index;
    logic signed [DATA_W-1:0] solution_value;
    logic                     singular;
    logic                     last_result;
  } out_item_t;

  // Request and response of the shared divider.
  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] num;
    logic signed [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [64:0] v);
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    hi = 65'sd2147483647;
    lo = -65'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gjs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gjs_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module gjs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] addr,
  input  wire  [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/gjs_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gjs_div: Q16.16 restoring divider
// Computes sat32((num*65536)/den) truncated toward zero, one bit per cycle.
// ----------------------------------------------------------------------------
module gjs_div (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire gjs_pkg::div_req_t req,
  output gjs_pkg::div_rsp_t      rsp
);

  localparam int NW = 48;

  logic [NW-1:0]  quo_r, quo_nxt;
  logic [NW:0]    rem_r, rem_nxt;
  logic [31:0]    den_r, den_nxt;
  logic           neg_r, neg_nxt;
  logic           busy_r, busy_nxt;
  logic [5:0]     cnt_r, cnt_nxt;
  logic           done_r, done_nxt;
  logic [NW:0]    trial;
  logic [NW:0]    shifted;
  logic [NW-1:0]  nabs;
  logic signed [64:0] sres;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    nabs     = '0;
    shifted  = '0;
    trial    = '0;
    if (req.start) begin
      nabs     = {(req.num[31] ? 32'(-req.num) : 32'(req.num)), 16'h0};
      quo_nxt  = nabs;
      rem_nxt  = '0;
      den_nxt  = req.den[31] ? 32'(-req.den) : 32'(req.den);
      neg_nxt  = req.num[31] ^ req.den[31];
      busy_nxt = 1'b1;
      cnt_nxt  = 6'(NW);
    end else if (busy_r) begin
      shifted = {rem_r[NW-1:0], quo_r[NW-1]};
      trial   = shifted - {17'h0, den_r};
      if (!trial[NW]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign sres     = neg_r ? -$signed({17'h0, quo_r}) : $signed({17'h0, quo_r});
  assign rsp.done = done_r;
  assign rsp.quo  = gjs_pkg::sat32(sres);

endmodule

`default_nettype wire

// ===== rtl/gjs_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gjs_seq: elimination sequencer
// Walks the pivot rows, drives the shared divider and the shared multiplier,
// and reads and writes the matrix RAM and the right-hand-side RAM.
// ----------------------------------------------------------------------------
module gjs_seq (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  input  wire  [gjs_pkg::IDX_W:0]         n_eff,
  output logic                            busy,
  output logic                            sing,
  // memory access, granted to this module while busy
  output logic                            mat_we,
  output logic [gjs_pkg::MAT_AW-1:0]      mat_addr,
  output logic [gjs_pkg::DATA_W-1:0]      mat_wdata,
  input  wire  [gjs_pkg::DATA_W-1:0]      mat_rdata,
  output logic                            rhs_we,
  output logic [gjs_pkg::IDX_W-1:0]       rhs_addr,
  output logic [gjs_pkg::DATA_W-1:0]      rhs_wdata,
  input  wire  [gjs_pkg::DATA_W-1:0]      rhs_rdata,
  output gjs_pkg::div_req_t               div_req,
  input  wire gjs_pkg::div_rsp_t          div_rsp
);

  localparam int IW = gjs_pkg::IDX_W;

  // Column index IW+1 wide: value MAX_N stands for the right-hand side.
  typedef enum logic [3:0] {
    S_IDLE, S_PRD, S_PCHK, S_DRD, S_DWAIT1, S_DSTART, S_DWAIT,
    S_FRD, S_FWAIT, S_ERD, S_EWAIT, S_EMUL, S_EWR
  } state_t;

  state_t            state_r, state_nxt;
  logic [IW-1:0]     r_r, r_nxt;
  logic [IW-1:0]     r2_r, r2_nxt;
  logic [IW:0]       c_r, c_nxt;
  logic signed [31:0] pivot_r, pivot_nxt;
  logic signed [31:0] factor_r, factor_nxt;
  logic signed [31:0] src_r, src_nxt;
  logic signed [31:0] dst_r, dst_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic               sing_r, sing_nxt;
  logic               busy_r, busy_nxt;
  logic [IW:0]        last_i;
  logic               c_rhs;
  logic signed [31:0] rdsel;
  logic signed [63:0] qm;
  logic signed [64:0] diff;

  assign last_i = n_eff - (IW+1)'(1);
  assign c_rhs  = c_r[IW];
  assign rdsel  = c_rhs ? rhs_rdata : mat_rdata;
  // Truncating divide by 65536 toward zero.
  assign qm     = (prod_r + ((prod_r < 0) ? 64'sd65535 : 64'sd0)) >>> 16;
  assign diff   = 65'(dst_r) - 65'(qm);

  function automatic logic [gjs_pkg::MAT_AW-1:0] maddr(input logic [IW-1:0] row,
                                                      input logic [IW-1:0] col);
    maddr = {row, col};
  endfunction

  always_comb begin
    state_nxt  = state_r;
    r_nxt      = r_r;
    r2_nxt     = r2_r;
    c_nxt      = c_r;
    pivot_nxt  = pivot_r;
    factor_nxt = factor_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    prod_nxt   = prod_r;
    sing_nxt   = sing_r;
    busy_nxt   = busy_r;
    mat_we     = 1'b0;
    mat_addr   = maddr(r_r, c_r[IW-1:0]);
    mat_wdata  = '0;
    rhs_we     = 1'b0;
    rhs_addr   = r_r;
    rhs_wdata  = '0;
    div_req    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          r_nxt     = '0;
          sing_nxt  = 1'b0;
          busy_nxt  = 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        mat_addr  = maddr(r_r, r_r);
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        pivot_nxt = mat_rdata;
        c_nxt     = (IW+1)'(gjs_pkg::MAX_N);
        if (mat_rdata == '0) begin
          sing_nxt  = 1'b1;
          busy_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DRD;
        end
      end
      // Normalize the pivot row: right-hand side first, then columns 0..n-1.
      S_DRD: begin
        mat_addr  = maddr(r_r, c_r[IW-1:0]);
        rhs_addr  = r_r;
        state_nxt = S_DWAIT1;
      end
      S_DWAIT1: begin
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        div_req.start = 1'b1;
        div_req.num   = rdsel;
        div_req.den   = pivot_r;
        mat_addr      = maddr(r_r, c_r[IW-1:0]);
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        mat_addr = maddr(r_r, c_r[IW-1:0]);
        if (div_rsp.done) begin
          if (c_rhs) begin
            rhs_we    = 1'b1;
            rhs_wdata = div_rsp.quo;
          end else begin
            mat_we    = 1'b1;
            mat_wdata = div_rsp.quo;
          end
          if (c_rhs) begin
            c_nxt     = '0;
            state_nxt = S_DRD;
          end else if (c_r == last_i) begin
            r2_nxt    = '0;
            state_nxt = S_FRD;
          end else begin
            c_nxt     = c_r + (IW+1)'(1);
            state_nxt = S_DRD;
          end
        end
      end
      // Fetch the factor of row r2 at column r.
      S_FRD: begin
        if ({1'b0, r2_r} > last_i) begin
          r_nxt = r_r + IW'(1);
          if ({1'b0, r_r} == last_i) begin
            busy_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_PRD;
          end
        end else if (r2_r == r_r) begin
          r2_nxt = r2_r + IW'(1);
          if (r2_r == IW'(gjs_pkg::MAX_N - 1)) begin
            r_nxt = r_r + IW'(1);
            busy_nxt  = ({1'b0, r_r} != last_i);
            state_nxt = ({1'b0, r_r} == last_i) ? S_IDLE : S_PRD;
          end
        end else begin
          mat_addr  = maddr(r2_r, r_r);
          state_nxt = S_FWAIT;
        end
      end
      S_FWAIT: begin
        factor_nxt = mat_rdata;
        c_nxt      = (IW+1)'(gjs_pkg::MAX_N);
        state_nxt  = S_ERD;
      end
      // Eliminate: read source (row r) then destination (row r2).
      S_ERD: begin
        mat_addr  = maddr(r_r, c_r[IW-1:0]);
        rhs_addr  = r_r;
        state_nxt = S_EWAIT;
      end
      S_EWAIT: begin
        src_nxt   = rdsel;
        mat_addr  = maddr(r2_r, c_r[IW-1:0]);
        rhs_addr  = r2_r;
        state_nxt = S_EMUL;
      end
      S_EMUL: begin
        dst_nxt   = rdsel;
        prod_nxt  = 64'(factor_r) * 64'(src_r);
        state_nxt = S_EWR;
      end
      S_EWR: begin
        mat_addr = maddr(r2_r, c_r[IW-1:0]);
        rhs_addr = r2_r;
        if (c_rhs) begin
          rhs_we    = 1'b1;
          rhs_wdata = gjs_pkg::sat32(diff);
          c_nxt     = '0;
          state_nxt = S_ERD;
        end else begin
          mat_we    = 1'b1;
          mat_wdata = gjs_pkg::sat32(diff);
          if (c_r == last_i) begin
            r2_nxt    = r2_r + IW'(1);
            state_nxt = ({1'b0, r2_r} == last_i) ? S_FRD : S_FRD;
            if ({1'b0, r2_r} == last_i) begin
              r_nxt     = r_r + IW'(1);
              busy_nxt  = ({1'b0, r_r} != last_i);
              state_nxt = ({1'b0, r_r} == last_i) ? S_IDLE : S_PRD;
            end
          end else begin
            c_nxt     = c_r + (IW+1)'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      sing_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      sing_r  <= sing_nxt;
    end
    r_r      <= r_nxt;
    r2_r     <= r2_nxt;
    c_r      <= c_nxt;
    pivot_r  <= pivot_nxt;
    factor_r <= factor_nxt;
    src_r    <= src_nxt;
    dst_r    <= dst_nxt;
    prod_r   <= prod_nxt;
  end

  assign busy = busy_r;
  assign sing = sing_r;

endmodule

`default_nettype wire

// ===== rtl/gauss_jordan_solver_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gauss_jordan_solver_top: Q16.16 linear system solver
// Loads A and b entry by entry, solves A*x = b by Gauss-Jordan elimination
// without row exchange and streams out x.
// ----------------------------------------------------------------------------
// A load transfer is taken every cycle while the block is idle; each writes
// one matrix entry (column below MAX_N) or one right-hand-side entry (column
// equal to MAX_N). The transfer flagged last starts the solve, during which
// in_stall is high. The solve is set by one shared restoring divider, which
// divides each pivot-row element (n+1 elements per row), and one shared
// multiplier that serves each eliminated element through the single-port
// matrix RAM. After it, n results leave one at a time, each read from the RAM
// and then held until it is transferred while out_stall is low, index 0
// first, last_result on index n-1.
// A zero pivot ends the solve early and all results carry singular = 1 and a
// zero value. Entries must be written before the solve reads them.
module gauss_jordan_solver_top (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire gjs_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire                    out_stall,
  output gjs_pkg::out_item_t     out_data,
  input  wire                    cfg_we,
  input  wire  [gjs_pkg::SIZE_W-1:0] cfg_wdata
);

  localparam int IW = gjs_pkg::IDX_W;

  typedef enum logic [1:0] {T_LOAD, T_SOLVE, T_READ, T_EMIT} top_state_t;

  top_state_t            st_r, st_nxt;
  logic [gjs_pkg::SIZE_W-1:0] size_r;
  logic [IW:0]           n_eff;
  logic [IW-1:0]         oi_r, oi_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  seq_start, seq_busy, seq_sing;
  logic                  in_acc;
  logic                  mat_we, rhs_we, s_mat_we, s_rhs_we;
  logic [gjs_pkg::MAT_AW-1:0] mat_addr, s_mat_addr;
  logic [IW-1:0]         rhs_addr, s_rhs_addr;
  logic [31:0]           mat_wdata, rhs_wdata, s_mat_wdata, s_rhs_wdata;
  logic [31:0]           mat_rdata, rhs_rdata;
  gjs_pkg::div_req_t     div_req;
  gjs_pkg::div_rsp_t     div_rsp;
  logic                  wr_mat, wr_rhs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= gjs_pkg::SIZE_W'(16);
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  // Size 0 counts as 1, sizes above MAX_N as MAX_N.
  always_comb begin
    if (size_r == '0) begin
      n_eff = (IW+1)'(1);
    end else if (32'(size_r) > gjs_pkg::MAX_N) begin
      n_eff = (IW+1)'(gjs_pkg::MAX_N);
    end else begin
      n_eff = (IW+1)'(size_r);
    end
  end

  assign in_stall = (st_r != T_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign wr_mat   = in_acc && (in_data.col_index < (IW+1)'(gjs_pkg::MAX_N));
  assign wr_rhs   = in_acc && (in_data.col_index == (IW+1)'(gjs_pkg::MAX_N));
  assign seq_start = in_acc && in_data.last_entry;

  // The load side owns the RAMs while idle, the sequencer while solving,
  // and the emit path reads the right-hand side afterwards.
  always_comb begin
    if (st_r == T_LOAD) begin
      mat_we    = wr_mat;
      mat_addr  = {in_data.row_index, in_data.col_index[IW-1:0]};
      mat_wdata = in_data.entry_value;
      rhs_we    = wr_rhs;
      rhs_addr  = in_data.row_index;
      rhs_wdata = in_data.entry_value;
    end else if (st_r == T_SOLVE) begin
      mat_we    = s_mat_we;
      mat_addr  = s_mat_addr;
      mat_wdata = s_mat_wdata;
      rhs_we    = s_rhs_we;
      rhs_addr  = s_rhs_addr;
      rhs_wdata = s_rhs_wdata;
    end else begin
      mat_we    = 1'b0;
      mat_addr  = s_mat_addr;
      mat_wdata = s_mat_wdata;
      rhs_we    = 1'b0;
      rhs_addr  = oi_nxt;
      rhs_wdata = s_rhs_wdata;
    end
  end

  gjs_ram #(.WIDTH(32), .DEPTH(gjs_pkg::MAT_DEPTH)) u_mat (
    .clk(clk), .we(mat_we), .addr(mat_addr), .wdata(mat_wdata), .rdata(mat_rdata)
  );

  gjs_ram #(.WIDTH(32), .DEPTH(gjs_pkg::MAX_N)) u_rhs (
    .clk(clk), .we(rhs_we), .addr(rhs_addr), .wdata(rhs_wdata), .rdata(rhs_rdata)
  );

  gjs_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  gjs_seq u_seq (
    .clk(clk), .rst_n(rst_n), .start(seq_start), .n_eff(n_eff),
    .busy(seq_busy), .sing(seq_sing),
    .mat_we(s_mat_we), .mat_addr(s_mat_addr), .mat_wdata(s_mat_wdata),
    .mat_rdata(mat_rdata),
    .rhs_we(s_rhs_we), .rhs_addr(s_rhs_addr), .rhs_wdata(s_rhs_wdata),
    .rhs_rdata(rhs_rdata),
    .div_req(div_req), .div_rsp(div_rsp)
  );

  // Emit: the RHS RAM holds the solution. T_READ issues the read of index
  // oi, T_EMIT holds the registered result until it is transferred.
  always_comb begin
    st_nxt        = st_r;
    oi_nxt        = oi_r;
    out_valid_nxt = out_valid_r;
    unique case (st_r)
      T_LOAD: begin
        if (seq_start) begin
          st_nxt = T_SOLVE;
        end
      end
      T_SOLVE: begin
        oi_nxt = '0;
        if (!seq_busy && !seq_start) begin
          st_nxt = T_READ;
        end
      end
      T_READ: begin
        out_valid_nxt = 1'b1;
        st_nxt        = T_EMIT;
      end
      T_EMIT: begin
        if (out_valid_r && !out_stall) begin
          out_valid_nxt = 1'b0;
          if ({1'b0, oi_r} == n_eff - (IW+1)'(1)) begin
            st_nxt = T_LOAD;
          end else begin
            oi_nxt = oi_r + IW'(1);
            st_nxt = T_READ;
          end
        end
      end
      default: st_nxt = T_LOAD;
    endcase
  end

  logic solve_go_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_LOAD;
      out_valid_r <= 1'b0;
      solve_go_r  <= 1'b0;
    end else begin
      // Keep SOLVE while the registered start flag is set so the sequencer's busy is seen.
      solve_go_r  <= seq_start;
      st_r        <= (st_r == T_SOLVE && solve_go_r) ? T_SOLVE : st_nxt;
      out_valid_r <= out_valid_nxt;
    end
    oi_r <= oi_nxt;
  end

  assign out_valid               = out_valid_r;
  assign out_data.solution_index = oi_r;
  assign out_data.solution_value = seq_sing ? '0 : rhs_rdata;
  assign out_data.singular       = seq_sing;
  assign out_data.last_result    = ({1'b0, oi_r} == n_eff - (IW+1)'(1));

  // No load transfer is taken while results are pending.
  a_no_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("load accepted while emitting");

  // The sequencer is never busy while loading.
  a_seq_idle_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == T_LOAD) |-> !seq_busy)
    else $error("sequencer busy during load");

  // A result is only shown after the solve has finished.
  a_valid_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(st_r == T_READ))
    else $error("result without read");

endmodule

`default_nettype wire
